>>> rtl/core/sfd_pkg.sv
package sfd_pkg;

	// sample and gain formats
	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 16;
	localparam int DELAY_W  = 14;
	localparam int Q_FRAC   = 15;

	// product of an 18-bit signed gain and a sample, their sum, the floored sum
	localparam int PROD_W = GAIN_W + 2 + SAMPLE_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int SHR_W  = SUM_W - Q_FRAC;
	localparam int EXT_W  = SHR_W + 1;

	localparam int DELAY_DEPTH_DEF = 8192;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BYPASS      = 3'd0,
		REG_DELAY_LEFT  = 3'd1,
		REG_DELAY_RIGHT = 3'd2,
		REG_FB_LEFT     = 3'd3,
		REG_FB_RIGHT    = 3'd4,
		REG_CROSS_GAIN  = 3'd5,
		REG_MIX_LEFT    = 3'd6,
		REG_MIX_RIGHT   = 3'd7
	} reg_idx_t;

	localparam logic [GAIN_W-1:0]  UNITY_G   = 16'h8000;
	localparam logic [DELAY_W-1:0] DELAY_RST = 14'd4096;
	localparam logic [GAIN_W-1:0]  HALF_G    = 16'h4000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// gains seen by one channel
	typedef struct packed {
		logic [GAIN_W-1:0] fb_own;
		logic [GAIN_W-1:0] fb_oth;
		logic [GAIN_W-1:0] mix;
	} sfd_gain_t;

	localparam sample_t S24_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t S24_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	function automatic logic [GAIN_W-1:0] gain_sat(logic [GAIN_W-1:0] g);
		return (g > UNITY_G) ? UNITY_G : g;
	endfunction

	function automatic sample_t sat24(logic [EXT_W-1:0] v);
		if (v[EXT_W-1:SAMPLE_W-1] == {(EXT_W-SAMPLE_W+1){v[EXT_W-1]}})
			return v[SAMPLE_W-1:0];
		return v[EXT_W-1] ? S24_MIN : S24_MAX;
	endfunction

endpackage

>>> rtl/core/sfd_if.sv
interface sfd_in_if;
	import sfd_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_left;
	sample_t sample_right;

	modport source(output valid, sample_left, sample_right, input ready);
	modport sink(input valid, sample_left, sample_right, output ready);
endinterface

interface sfd_out_if;
	import sfd_pkg::*;

	logic    valid;
	logic    ready;
	sample_t out_left;
	sample_t out_right;

	modport source(output valid, out_left, out_right, input ready);
	modport sink(input valid, out_left, out_right, output ready);
endinterface

>>> rtl/core/stereo_cross_feedback_delay_top.sv
// Stereo feedback delay with cross feedback.
// samples (sink): one stereo pair per transfer, signed 24-bit left/right.
// results (source): one output pair per accepted input pair, in order.
// cfg_wen/cfg_index/cfg_data: register write port, to be written only while
// idle; the user is bound to this and the block itself does not enforce it.
// A result passes stage 1, stage 2 and the output register; it waits in stage 2
// while the previous result has not been taken. No pair is taken while one is
// in stage 1: the delayed samples are read at the input transfer, the new ones
// are written back from stage 2, and the next pair's read is issued on that
// write edge; a last-write register forwards the entry just written when the
// delay is one.
// Reset: config registers take their defaults, write position goes to zero.
// The memories are not swept; a fill flag plus the write position mark which
// entries were ever written, and an unwritten entry reads as zero, so pairs
// are taken as soon as the run flag is set after reset is released.
// Stall: a finished result sits in the output register while one more pair
// is taken and processed; it then waits in the last stage and ready drops
// until the receiver takes the result.
// Bypass: the result equals the input and neither memory nor the write
// position changes.
module stereo_cross_feedback_delay_top #(
	parameter int DELAY_DEPTH = sfd_pkg::DELAY_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [sfd_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [sfd_pkg::CFG_W-1:0]      cfg_data,
	sfd_in_if.sink                         samples,
	sfd_out_if.source                      results
);
	import sfd_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int DW = AW + 1;
	localparam logic [DW-1:0] DEPTH_D  = DW'(DELAY_DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);

	// read slot: (wp - clamp(dly, 1, depth)) mod depth
	function automatic logic [AW-1:0] slot_of(logic [AW-1:0] wp, logic [DELAY_W-1:0] dly);
		logic [DW-1:0] dcl;
		logic [DW-1:0] sum;
		if (dly == '0)
			dcl = DW'(1);
		else if (32'(dly) > 32'(DELAY_DEPTH))
			dcl = DEPTH_D;
		else
			dcl = DW'(dly);
		sum = {1'b0, wp} + DEPTH_D - dcl;
		if (sum >= DEPTH_D)
			sum = sum - DEPTH_D;
		return sum[AW-1:0];
	endfunction

	// configuration registers
	logic               bypass_q;
	logic [DELAY_W-1:0] dly_l_q, dly_r_q;
	logic [GAIN_W-1:0]  fb_l_q, fb_r_q, cg_q, mix_l_q, mix_r_q;

	// position and fill tracking
	logic [AW-1:0] wp_q;
	logic          full_q;
	logic          run_q;

	logic          accept;
	logic [AW-1:0] slot_l, slot_r;
	logic          ok_l, ok_r;

	// stage 1: memory data returns
	logic          s1_vld_q;
	logic          byp_s1;
	logic [AW-1:0] wa_s1, ra_l_s1, ra_r_s1;
	logic          ok_l_s1, ok_r_s1;
	sample_t       x_l_s1, x_r_s1;
	sample_t       rd_l, rd_r;
	sample_t       d_l, d_r;

	// last write, for forwarding into stage 1
	logic          lw_vld_q;
	logic [AW-1:0] lw_addr_q;
	sample_t       lw_l_q, lw_r_q;

	// stage 2: products registered, sums and saturation
	logic          s2_vld_q;
	logic          byp_s2;
	logic [AW-1:0] wa_s2;
	logic          s2_go;
	logic          we;
	sample_t       dry_l, wet_l, st_l;
	sample_t       dry_r, wet_r, st_r;
	sfd_gain_t     gain_l, gain_r;

	// output register
	logic    out_vld_q;
	sample_t out_l_q, out_r_q;

	always_comb begin
		s2_go         = s2_vld_q && (!out_vld_q || results.ready);
		we            = s2_go && !byp_s2;
		samples.ready = run_q && !s1_vld_q && (!s2_vld_q || s2_go);
		accept        = samples.valid && samples.ready;
		slot_l        = slot_of(wp_q, dly_l_q);
		slot_r        = slot_of(wp_q, dly_r_q);
		ok_l          = full_q || (slot_l < wp_q);
		ok_r          = full_q || (slot_r < wp_q);
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			dly_l_q  <= DELAY_RST;
			dly_r_q  <= DELAY_RST;
			fb_l_q   <= HALF_G;
			fb_r_q   <= HALF_G;
			cg_q     <= '0;
			mix_l_q  <= HALF_G;
			mix_r_q  <= HALF_G;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_BYPASS:      bypass_q <= cfg_data[0];
				REG_DELAY_LEFT:  dly_l_q  <= cfg_data[DELAY_W-1:0];
				REG_DELAY_RIGHT: dly_r_q  <= cfg_data[DELAY_W-1:0];
				REG_FB_LEFT:     fb_l_q   <= cfg_data;
				REG_FB_RIGHT:    fb_r_q   <= cfg_data;
				REG_CROSS_GAIN:  cg_q     <= cfg_data;
				REG_MIX_LEFT:    mix_l_q  <= cfg_data;
				REG_MIX_RIGHT:   mix_r_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			wp_q      <= '0;
			full_q    <= 1'b0;
			s1_vld_q  <= 1'b0;
			s2_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
			lw_vld_q  <= 1'b0;
		end else begin
			run_q    <= 1'b1;
			s1_vld_q <= accept;
			if (accept && !bypass_q) begin
				if (wp_q == LAST_POS) begin
					wp_q   <= '0;
					full_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
			if (s1_vld_q)
				s2_vld_q <= 1'b1;
			else if (s2_go)
				s2_vld_q <= 1'b0;
			if (s2_go)
				out_vld_q <= 1'b1;
			else if (results.ready)
				out_vld_q <= 1'b0;
			if (we)
				lw_vld_q <= 1'b1;
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			byp_s1  <= bypass_q;
			wa_s1   <= wp_q;
			ra_l_s1 <= slot_l;
			ra_r_s1 <= slot_r;
			ok_l_s1 <= ok_l;
			ok_r_s1 <= ok_r;
			x_l_s1  <= samples.sample_left;
			x_r_s1  <= samples.sample_right;
		end
		if (s1_vld_q) begin
			byp_s2 <= byp_s1;
			wa_s2  <= wa_s1;
		end
		if (we) begin
			lw_addr_q <= wa_s2;
			lw_l_q    <= st_l;
			lw_r_q    <= st_r;
		end
		if (s2_go) begin
			out_l_q <= byp_s2 ? dry_l : wet_l;
			out_r_q <= byp_s2 ? dry_r : wet_r;
		end
	end

	// forward the entry written on the read edge; unwritten entries read zero
	always_comb begin
		if (lw_vld_q && (lw_addr_q == ra_l_s1))
			d_l = lw_l_q;
		else
			d_l = ok_l_s1 ? rd_l : '0;
		if (lw_vld_q && (lw_addr_q == ra_r_s1))
			d_r = lw_r_q;
		else
			d_r = ok_r_s1 ? rd_r : '0;
		gain_l = '{fb_own: fb_l_q, fb_oth: cg_q, mix: mix_l_q};
		gain_r = '{fb_own: fb_r_q, fb_oth: cg_q, mix: mix_r_q};
	end

	sfd_mem #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_mem_l (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (slot_l),
		.rd_data (rd_l),
		.wr_en   (we),
		.wr_addr (wa_s2),
		.wr_data (st_l)
	);

	sfd_mem #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_mem_r (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (slot_r),
		.rd_data (rd_r),
		.wr_en   (we),
		.wr_addr (wa_s2),
		.wr_data (st_r)
	);

	sfd_chan u_chan_l (
		.clk   (clk),
		.en    (s1_vld_q),
		.x     (x_l_s1),
		.d_own (d_l),
		.d_oth (d_r),
		.gain  (gain_l),
		.dry   (dry_l),
		.wet   (wet_l),
		.store (st_l)
	);

	sfd_chan u_chan_r (
		.clk   (clk),
		.en    (s1_vld_q),
		.x     (x_r_s1),
		.d_own (d_r),
		.d_oth (d_l),
		.gain  (gain_r),
		.dry   (dry_r),
		.wet   (wet_r),
		.store (st_r)
	);

	assign results.valid     = out_vld_q;
	assign results.out_left  = out_l_q;
	assign results.out_right = out_r_q;

endmodule

>>> rtl/core/sfd_mem.sv
module sfd_mem #(
	parameter int DEPTH = sfd_pkg::DELAY_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output sfd_pkg::sample_t rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  sfd_pkg::sample_t wr_data
);
	import sfd_pkg::*;

	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read-before-write on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/sfd_chan.sv
module sfd_chan (
	input  logic               clk,
	input  logic               en,
	input  sfd_pkg::sample_t   x,
	input  sfd_pkg::sample_t   d_own,
	input  sfd_pkg::sample_t   d_oth,
	input  sfd_pkg::sfd_gain_t gain,
	output sfd_pkg::sample_t   dry,
	output sfd_pkg::sample_t   wet,
	output sfd_pkg::sample_t   store
);
	import sfd_pkg::*;

	logic [GAIN_W-1:0] mix_g;
	logic [GAIN_W-1:0] fb_g;
	logic [GAIN_W-1:0] cr_g;
	logic [GAIN_W:0]   dry_g;

	logic signed [PROD_W-1:0] p_dry_s2;
	logic signed [PROD_W-1:0] p_wet_s2;
	logic signed [PROD_W-1:0] p_fb_s2;
	logic signed [PROD_W-1:0] p_cr_s2;
	sample_t                  x_s2;

	logic [SUM_W-1:0] mix_sum;
	logic [SUM_W-1:0] fb_sum;
	logic [SHR_W-1:0] mix_shr;
	logic [SHR_W-1:0] fb_shr;
	logic [EXT_W-1:0] st_sum;

	always_comb begin
		mix_g = gain_sat(gain.mix);
		fb_g  = gain_sat(gain.fb_own);
		cr_g  = gain_sat(gain.fb_oth);
		dry_g = {1'b0, UNITY_G} - {1'b0, mix_g};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_dry_s2 <= $signed({1'b0, dry_g}) * x;
			p_wet_s2 <= $signed({2'b00, mix_g}) * d_own;
			p_fb_s2  <= $signed({2'b00, fb_g}) * d_own;
			p_cr_s2  <= $signed({2'b00, cr_g}) * d_oth;
			x_s2     <= x;
		end
	end

	// floor by dropping the fraction bits of the exact sum
	always_comb begin
		mix_sum = {p_dry_s2[PROD_W-1], p_dry_s2} + {p_wet_s2[PROD_W-1], p_wet_s2};
		fb_sum  = {p_fb_s2[PROD_W-1], p_fb_s2} + {p_cr_s2[PROD_W-1], p_cr_s2};
		mix_shr = mix_sum[SUM_W-1:Q_FRAC];
		fb_shr  = fb_sum[SUM_W-1:Q_FRAC];
		st_sum  = {{(EXT_W-SAMPLE_W){x_s2[SAMPLE_W-1]}}, x_s2} + {fb_shr[SHR_W-1], fb_shr};
		dry     = x_s2;
		wet     = sat24({mix_shr[SHR_W-1], mix_shr});
		store   = sat24(st_sum);
	end

endmodule

>>> rtl/core/sfd_chk.sv
module sfd_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input sfd_pkg::sample_t out_left,
	input sfd_pkg::sample_t out_right
);
	import sfd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
		else $error("result changed while stalled");

	// no back-to-back input transfers
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back-to-back cycles");

	// a fresh result has a matching earlier input transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result without matching input transfer");

endmodule

bind stereo_cross_feedback_delay_top sfd_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_left  (results.out_left),
	.out_right (results.out_right)
);

>>> bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfd_pkg::*;

	localparam int     DEPTH       = DELAY_DEPTH_DEF;
	localparam longint ONE_Q15     = 32768;
	localparam int     CYCLE_LIMIT = 600000;
	localparam int     RAND_PHASES = 12;
	localparam int     PHASE_ITEMS = 94;
	localparam int     TAIL_CYCLES = 10;

	// one stereo pair as it leaves the block
	typedef struct packed {
		sample_t left;
		sample_t right;
	} pair_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	sfd_in_if  in_ch();
	sfd_out_if out_ch();

	stereo_cross_feedback_delay_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (in_ch),
		.results   (out_ch)
	);

	// Shadow copy of the register file, kept in the masked form the block holds.
	logic               bypass_on;
	logic [DELAY_W-1:0] delay_l, delay_r;
	logic [GAIN_W-1:0]  fb_l, fb_r, cross_g, mix_l, mix_r;

	// Shadow delay lines and the shared write head.
	sample_t     left_line  [DEPTH];
	sample_t     right_line [DEPTH];
	int unsigned head;

	// Output pairs still owed by the block, oldest first.
	pair_t owed_pairs[$];

	int unsigned cycle_count;
	int          errors;
	int          items_sent;
	int          pairs_checked;
	int          settings_used;
	bit          gaps_on;
	bit          stalls_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Hard stop in case the handshake locks up.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d pairs still owed",
			$time, cycle_count, owed_pairs.size());
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------- prediction

	// Q1.15 gain, anything above unity is clamped to unity
	function automatic longint q15_gain(logic [GAIN_W-1:0] g);
		return (g > UNITY_G) ? ONE_Q15 : longint'(g);
	endfunction

	function automatic sample_t clamp24(longint v);
		if (v > 64'sd8388607)
			return S24_MAX;
		if (v < -64'sd8388608)
			return S24_MIN;
		return sample_t'(v);
	endfunction

	// Tap position: delay zero acts as one, anything past the depth hits the
	// slot about to be overwritten (old content).
	function automatic int unsigned tap_slot(logic [DELAY_W-1:0] dly);
		int unsigned d;
		d = dly;
		if (d < 1)
			d = 1;
		if (d > DEPTH)
			d = DEPTH;
		return (head + DEPTH - d) % DEPTH;
	endfunction

	// Computes the output pair for one input pair and advances the shadow lines.
	function automatic pair_t echo_predict(sample_t in_l, sample_t in_r);
		longint xl, xr, dl, dr, ml, mr, cg;
		pair_t  res;
		xl = in_l;
		xr = in_r;
		if (bypass_on) begin
			res.left  = in_l;
			res.right = in_r;
			return res;
		end
		// both taps are read before the head slot is overwritten
		dl = left_line[tap_slot(delay_l)];
		dr = right_line[tap_slot(delay_r)];
		ml = q15_gain(mix_l);
		mr = q15_gain(mix_r);
		cg = q15_gain(cross_g);
		// >>> on a signed 64-bit value is floor division by 32768
		res.left  = clamp24(((ONE_Q15 - ml) * xl + ml * dl) >>> Q_FRAC);
		res.right = clamp24(((ONE_Q15 - mr) * xr + mr * dr) >>> Q_FRAC);
		left_line[head]  = clamp24(xl + ((q15_gain(fb_l) * dl + cg * dr) >>> Q_FRAC));
		right_line[head] = clamp24(xr + ((q15_gain(fb_r) * dr + cg * dl) >>> Q_FRAC));
		head = (head + 1) % DEPTH;
		return res;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void check_field(string name, sample_t want, sample_t got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Every result transfer is matched against the oldest owed pair.
	always @(posedge clk) begin : result_check
		pair_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (owed_pairs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, got %0d / %0d", $time,
					out_ch.out_left, out_ch.out_right);
			end else begin
				want = owed_pairs.pop_front();
				check_field("out_left", want.left, out_ch.out_left);
				check_field("out_right", want.right, out_ch.out_right);
				pairs_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- idling

	// mostly back to back or short, now and then a long pause
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Receiver: alternating runs of ready high and stalls, or ready always high when stalls are off.
	initial begin : result_sink
		int run, hold;
		out_ch.ready = 1'b0;
		forever begin
			if (!stalls_on) begin
				@(negedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				run  = 1 + pick_pause();
				hold = pick_pause();
				repeat (run) begin
					@(negedge clk);
					out_ch.ready <= 1'b1;
				end
				repeat (hold) begin
					@(negedge clk);
					out_ch.ready <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// Register write; the shadow copy keeps the bits the register holds.
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_BYPASS:      bypass_on = val[0];
			REG_DELAY_LEFT:  delay_l   = val[DELAY_W-1:0];
			REG_DELAY_RIGHT: delay_r   = val[DELAY_W-1:0];
			REG_FB_LEFT:     fb_l      = val;
			REG_FB_RIGHT:    fb_r      = val;
			REG_CROSS_GAIN:  cross_g   = val;
			REG_MIX_LEFT:    mix_l     = val;
			REG_MIX_RIGHT:   mix_r     = val;
			default: begin
			end
		endcase
	endtask

	task automatic load_setting(logic byp, logic [CFG_W-1:0] dly_l, logic [CFG_W-1:0] dly_r,
			logic [CFG_W-1:0] g_fbl, logic [CFG_W-1:0] g_fbr, logic [CFG_W-1:0] g_cross,
			logic [CFG_W-1:0] g_mixl, logic [CFG_W-1:0] g_mixr);
		write_reg(REG_BYPASS, {{(CFG_W-1){1'b0}}, byp});
		write_reg(REG_DELAY_LEFT, dly_l);
		write_reg(REG_DELAY_RIGHT, dly_r);
		write_reg(REG_FB_LEFT, g_fbl);
		write_reg(REG_FB_RIGHT, g_fbr);
		write_reg(REG_CROSS_GAIN, g_cross);
		write_reg(REG_MIX_LEFT, g_mixl);
		write_reg(REG_MIX_RIGHT, g_mixr);
		settings_used++;
	endtask

	// One input transfer, then an optional gap with valid low.
	task automatic send_pair(sample_t l, sample_t r);
		int gap;
		@(negedge clk);
		in_ch.valid        <= 1'b1;
		in_ch.sample_left  <= l;
		in_ch.sample_right <= r;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		owed_pairs.push_back(echo_predict(l, r));
		items_sent++;
		gap = gaps_on ? pick_pause() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop sending and wait for every owed pair; the tail covers the pipeline so
	// the block is idle before any register write.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (owed_pairs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic sample_t rand_sample();
		logic [31:0] w;
		int          r;
		w = $urandom();
		r = $urandom_range(0, 9);
		if (r == 0)
			return S24_MAX;
		if (r == 1)
			return S24_MIN;
		if (r == 2)
			return sample_t'($urandom_range(0, 511)) - sample_t'(256);
		return w[SAMPLE_W-1:0];
	endfunction

	// short delays dominate so echoes come back inside a phase
	function automatic logic [CFG_W-1:0] rand_delay_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return CFG_W'($urandom_range(8193, 65535));
		if (r == 2)
			return CFG_W'(DEPTH);
		if (r == 3)
			return CFG_W'($urandom_range(41, DEPTH - 1));
		return CFG_W'($urandom_range(1, 40));
	endfunction

	function automatic logic [CFG_W-1:0] rand_gain_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return UNITY_G;
		if (r == 2)
			return CFG_W'($urandom_range(32769, 65535));
		return CFG_W'($urandom_range(0, 32768));
	endfunction

	// ---------------------------------------------------------------- tests

	// Reset values: half wet, delay 4096, so only the dry half shows up.
	task automatic test_defaults();
		send_pair(S24_MAX, S24_MIN);
		send_pair(S24_MIN, S24_MAX);
		send_pair('0, -24'sd1);
		send_pair(24'sd1, '0);
	endtask

	// Unity feedback plus unity cross feedback on short delays drives the
	// stored values into saturation; left is all wet, right all dry.
	task automatic test_saturation();
		settle();
		load_setting(1'b0, 16'd1, 16'd2, UNITY_G, UNITY_G, UNITY_G, UNITY_G, 16'd0);
		repeat (3) send_pair(S24_MAX, S24_MAX);
		repeat (3) send_pair(S24_MIN, S24_MIN);
	endtask

	// Delay zero, delay above the depth, gains above unity, masked delay word.
	task automatic test_register_limits();
		settle();
		load_setting(1'b0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h8001, 16'hFFFF, 16'hFFFF,
			16'h9000);
		send_pair(S24_MAX, 24'sd12345);
		send_pair(-24'sd777, S24_MIN);
		send_pair(S24_MIN, S24_MAX);
		send_pair(24'sd1, -24'sd1);
		settle();
		write_reg(REG_DELAY_LEFT, 16'h4001);
		write_reg(REG_DELAY_RIGHT, CFG_W'(DEPTH));
		send_pair(24'sd4096, -24'sd4096);
		send_pair(S24_MAX, S24_MIN);
	endtask

	// Bypass passes samples through and freezes the lines: the first pairs
	// after leaving bypass must echo what was stored before it.
	task automatic test_bypass();
		settle();
		write_reg(REG_BYPASS, 16'd1);
		send_pair(S24_MAX, S24_MIN);
		send_pair(S24_MIN, S24_MAX);
		send_pair(-24'sd1, 24'sd3);
		settle();
		write_reg(REG_BYPASS, 16'd0);
		send_pair('0, '0);
		send_pair(24'sd100, -24'sd100);
	endtask

	// Random settings, each followed by a run of random pairs. Some phases run
	// with no gaps or stalls; some pause mid-run until every result is back.
	task automatic test_random_phases();
		logic byp;
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			gaps_on   = (p % 4 != 1);
			stalls_on = (p % 4 != 1);
			byp = (p == 3) || ($urandom_range(0, 7) == 0);
			load_setting(byp, rand_delay_word(), rand_delay_word(), rand_gain_word(),
				rand_gain_word(), rand_gain_word(), rand_gain_word(), rand_gain_word());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && p % 3 == 0)
					settle();
				send_pair(rand_sample(), rand_sample());
			end
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		arst_n             = 1'b0;
		cfg_wen            = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		in_ch.valid        = 1'b0;
		in_ch.sample_left  = '0;
		in_ch.sample_right = '0;
		cycle_count        = 0;
		errors             = 0;
		items_sent         = 0;
		pairs_checked      = 0;
		settings_used      = 1;
		gaps_on            = 1'b1;
		stalls_on          = 1'b1;

		// shadow state at its reset values
		bypass_on = 1'b0;
		delay_l   = DELAY_RST;
		delay_r   = DELAY_RST;
		fb_l      = HALF_G;
		fb_r      = HALF_G;
		cross_g   = '0;
		mix_l     = HALF_G;
		mix_r     = HALF_G;
		head      = 0;
		for (int i = 0; i < DEPTH; i++) begin
			left_line[i]  = '0;
			right_line[i] = '0;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_saturation();
		test_register_limits();
		test_bypass();
		test_random_phases();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d stereo pairs under %0d register settings (bypass, delay and gain",
			items_sent, settings_used);
		$display("limits, saturation); %0d results checked, %0d mismatches",
			pairs_checked, errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
